// ===== src/atm_pkg.sv =====
package atm_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_N           = 24;
    localparam int CW               = 34;
    localparam int ANG_W            = 36;
    localparam int PW               = 68;

    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
    localparam logic signed [CW-1:0] RAD_PER_DEG = CW'(74961321);

    localparam logic [2:0] ACT_WRITE     = 3'd0;
    localparam logic [2:0] ACT_READ      = 3'd1;
    localparam logic [2:0] ACT_TRANSLATE = 3'd2;
    localparam logic [2:0] ACT_SCALE     = 3'd3;
    localparam logic [2:0] ACT_ROTATE    = 3'd4;
    localparam logic [2:0] ACT_TRANSFORM = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TRANS,
        ST_SC_MUL,
        ST_SC_ACC,
        ST_VX_MUL,
        ST_VX_ACC,
        ST_VX_OUT,
        ST_RD_RED,
        ST_RD_FOLD,
        ST_RD_QUAD,
        ST_RD_MUL,
        ST_RD_ZINIT,
        ST_RD_CORDIC,
        ST_RD_TRIG,
        ST_RT_PMUL,
        ST_RT_PSAT,
        ST_RT_TMUL,
        ST_RT_DIAG,
        ST_RT_CMUL,
        ST_RT_CROSS,
        ST_MM_MUL,
        ST_MM_ACC,
        ST_MM_WB,
        ST_RT_FIN,
        ST_EMIT
    } state_t;

    function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0:    r = 32'h3243F6A8;
            5'd1:    r = 32'h1DAC6705;
            5'd2:    r = 32'h0FADBAFC;
            5'd3:    r = 32'h07F56EA6;
            5'd4:    r = 32'h03FEAB76;
            5'd5:    r = 32'h01FFD55B;
            5'd6:    r = 32'h00FFFAAA;
            5'd7:    r = 32'h007FFF55;
            5'd8:    r = 32'h003FFFEA;
            5'd9:    r = 32'h001FFFFD;
            5'd10:   r = 32'h000FFFFF;
            5'd11:   r = 32'h0007FFFF;
            5'd12:   r = 32'h0003FFFF;
            5'd13:   r = 32'h0001FFFF;
            5'd14:   r = 32'h0000FFFF;
            5'd15:   r = 32'h00007FFF;
            5'd16:   r = 32'h00003FFF;
            5'd17:   r = 32'h00001FFF;
            5'd18:   r = 32'h00000FFF;
            5'd19:   r = 32'h000007FF;
            5'd20:   r = 32'h000003FF;
            5'd21:   r = 32'h000001FF;
            5'd22:   r = 32'h000000FF;
            5'd23:   r = 32'h0000007F;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                                 input int unsigned n);
        logic signed [PW-1:0] h;
        h = PW'(1) <<< (n - 1);
        return (v + h) >>> n;
    endfunction

    function automatic logic ovf32(input logic signed [PW-1:0] v);
        return (v > PW'(64'sd2147483647)) || (v < -PW'(64'sd2147483648));
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        logic signed [31:0] r;
        if (v > PW'(64'sd2147483647)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -PW'(64'sd2147483648)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/atm_cordic.sv =====
module atm_cordic import atm_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [CW-1:0] z_in,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic                 done
);

    localparam int STEPS = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;
    localparam int IW    = $clog2(STEPS);

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [IW-1:0]        it_reg, it_next;
    logic                 busy_reg, busy_next, done_reg, done_next;
    logic signed [CW-1:0] dx, dy, ang;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg  <= x_next;
        y_reg  <= y_next;
        z_reg  <= z_next;
        it_reg <= it_next;
    end

    always_comb begin
        dx        = y_reg >>> it_reg;
        dy        = x_reg >>> it_reg;
        ang       = CW'(atan_q30(5'(it_reg)));
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = z_in;
            it_next   = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!z_reg[CW-1]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - ang;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + ang;
            end
            if (it_reg == IW'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                it_next = it_reg + 1'b1;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign done  = done_reg;

endmodule

// ===== src/affine_transform_matrix_unit_core.sv =====
// Keeps a 4x4 matrix of signed fixed-point elements and applies one action per request.
// Input channel s_*: action, element row and column, four operand components and an
// angle in degrees. Output channel m_*: one result per request (none for an undefined
// action), four for a vector transform, the final one marked by m_last.
// A single multiplier with a rounding accumulator, driven by a sequencer, does all
// products; a CORDIC unit gives sine and cosine one step per cycle.
// s_ready is high only while the sequencer is idle, so requests are handled one at a
// time. A rotate angle needs at most one 360 degree reduction at 16 fraction bits.
// A new request can be accepted in the cycle after the previous one loads its last result.
// The finished result sits in an output register; when the receiver stalls the block
// still starts the next request and waits only when that one has a result to hand over.
// After reset the matrix is all zero and no result is pending.
module affine_transform_matrix_unit_core import atm_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic [1:0]         s_row,
    input  logic [1:0]         s_col,
    input  logic signed [31:0] s_comp_x,
    input  logic signed [31:0] s_comp_y,
    input  logic signed [31:0] s_comp_z,
    input  logic signed [31:0] s_comp_w,
    input  logic signed [25:0] s_angle_deg,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value,
    output logic [3:0]         m_position,
    output logic               m_last,
    output logic               m_saturated
);

    localparam longint FULL_L = 360 * (longint'(1) << FRAC_BITS);
    localparam logic signed [ANG_W-1:0] A_FULL    = ANG_W'(FULL_L);
    localparam logic signed [ANG_W-1:0] A_HALF    = ANG_W'(FULL_L / 2);
    localparam logic signed [ANG_W-1:0] A_QUARTER = ANG_W'(FULL_L / 4);
    localparam logic signed [31:0]      ONE       = 32'(longint'(1) << FRAC_BITS);

    state_t state_reg, state_next;

    logic [2:0]           act_reg, act_next;
    logic [3:0]           idx_reg, idx_next;
    logic signed [31:0]   v_reg[4], v_next[4];
    logic signed [25:0]   deg_reg, deg_next;
    logic signed [31:0]   mat_reg[16], mat_next[16];
    logic signed [31:0]   rot_reg[9], rot_next[9];
    logic signed [31:0]   yv_reg[4], yv_next[4];
    logic signed [31:0]   col_reg[3], col_next[3];
    logic [1:0]           i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic signed [PW-1:0] acc_reg, acc_next, prod_reg, prod_next;
    logic signed [31:0]   p_reg, p_next;
    logic signed [CW-1:0] c_reg, c_next, s_reg, s_next, t_reg, t_next;
    logic signed [ANG_W-1:0] a_reg, a_next;
    logic                 flip_reg, flip_next, flag_reg, flag_next;
    logic signed [31:0]   e_val_reg, e_val_next;
    logic [3:0]           e_pos_reg, e_pos_next;
    logic                 mv_reg, mv_next, mlast_reg, mlast_next, msat_reg, msat_next;
    logic signed [31:0]   mval_reg, mval_next;
    logic [3:0]           mpos_reg, mpos_next;

    logic signed [CW-1:0] mul_a, mul_b, cx, cy, z_start;
    logic                 c_start, c_done, out_free;
    logic signed [PW-1:0] r_fb, r_30, accsum, tsum, ev;
    logic [1:0]           kk;
    logic [3:0]           rot_idx;

    atm_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (c_start),
        .z_in   (z_start),
        .x_out  (cx),
        .y_out  (cy),
        .done   (c_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            for (int n = 0; n < 16; n++) begin
                mat_reg[n] <= '0;
            end
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            mat_reg   <= mat_next;
        end
        act_reg   <= act_next;
        idx_reg   <= idx_next;
        v_reg     <= v_next;
        deg_reg   <= deg_next;
        rot_reg   <= rot_next;
        yv_reg    <= yv_next;
        col_reg   <= col_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        p_reg     <= p_next;
        c_reg     <= c_next;
        s_reg     <= s_next;
        t_reg     <= t_next;
        a_reg     <= a_next;
        flip_reg  <= flip_next;
        flag_reg  <= flag_next;
        e_val_reg <= e_val_next;
        e_pos_reg <= e_pos_next;
        mval_reg  <= mval_next;
        mpos_reg  <= mpos_next;
        mlast_reg <= mlast_next;
        msat_reg  <= msat_next;
    end

    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        idx_next   = idx_reg;
        v_next     = v_reg;
        deg_next   = deg_reg;
        mat_next   = mat_reg;
        rot_next   = rot_reg;
        yv_next    = yv_reg;
        col_next   = col_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        c_next     = c_reg;
        s_next     = s_reg;
        t_next     = t_reg;
        a_next     = a_reg;
        flip_next  = flip_reg;
        flag_next  = flag_reg;
        e_val_next = e_val_reg;
        e_pos_next = e_pos_reg;
        mval_next  = mval_reg;
        mpos_next  = mpos_reg;
        mlast_next = mlast_reg;
        msat_next  = msat_reg;
        mv_next    = mv_reg && !m_ready;
        out_free   = !mv_reg || m_ready;
        c_start    = 1'b0;
        z_start    = '0;
        mul_a      = '0;
        mul_b      = '0;

        r_fb    = rnd(prod_reg, FRAC_BITS);
        r_30    = rnd(prod_reg, 30);
        accsum  = acc_reg + r_fb;
        tsum    = PW'(mat_reg[{2'b11, i_reg}]) + PW'(v_reg[i_reg]);
        kk      = 2'd3 - i_reg - j_reg;
        rot_idx = 4'({2'b00, i_reg} * 4'd3) + {2'b00, k_reg};
        ev      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next   = s_action;
                    idx_next   = {s_row, s_col};
                    v_next[0]  = s_comp_x;
                    v_next[1]  = s_comp_y;
                    v_next[2]  = s_comp_z;
                    v_next[3]  = s_comp_w;
                    deg_next   = s_angle_deg;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                flag_next  = 1'b0;
                e_val_next = '0;
                e_pos_next = '0;
                i_next     = '0;
                j_next     = '0;
                k_next     = '0;
                acc_next   = '0;
                case (act_reg)
                    ACT_WRITE: begin
                        mat_next[idx_reg] = v_reg[0];
                        e_pos_next        = idx_reg;
                        state_next        = ST_EMIT;
                    end
                    ACT_READ: begin
                        e_val_next = mat_reg[idx_reg];
                        e_pos_next = idx_reg;
                        state_next = ST_EMIT;
                    end
                    ACT_TRANSLATE: state_next = ST_TRANS;
                    ACT_SCALE:     state_next = ST_SC_MUL;
                    ACT_ROTATE: begin
                        a_next     = ANG_W'(deg_reg);
                        state_next = ST_RD_RED;
                    end
                    ACT_TRANSFORM: state_next = ST_VX_MUL;
                    default:       state_next = ST_IDLE;
                endcase
            end
            ST_TRANS: begin
                mat_next[{2'b11, i_reg}] = sat32(tsum);
                flag_next = flag_reg | ovf32(tsum);
                if (i_reg == 2'd2) begin
                    state_next = ST_EMIT;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_SC_MUL: begin
                mul_a      = CW'(mat_reg[{i_reg, i_reg}]);
                mul_b      = CW'(v_reg[i_reg]);
                state_next = ST_SC_ACC;
            end
            ST_SC_ACC: begin
                mat_next[{i_reg, i_reg}] = sat32(r_fb);
                flag_next = flag_reg | ovf32(r_fb);
                if (i_reg == 2'd2) begin
                    state_next = ST_EMIT;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SC_MUL;
                end
            end
            ST_VX_MUL: begin
                mul_a      = CW'(mat_reg[{i_reg, j_reg}]);
                mul_b      = CW'(v_reg[j_reg]);
                state_next = ST_VX_ACC;
            end
            ST_VX_ACC: begin
                state_next = ST_VX_MUL;
                if (j_reg == 2'd3) begin
                    yv_next[i_reg] = sat32(accsum);
                    flag_next      = flag_reg | ovf32(accsum);
                    acc_next       = '0;
                    j_next         = '0;
                    if (i_reg == 2'd3) begin
                        i_next     = '0;
                        state_next = ST_VX_OUT;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    acc_next = accsum;
                    j_next   = j_reg + 1'b1;
                end
            end
            ST_VX_OUT: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mval_next  = yv_reg[i_reg];
                    mpos_next  = {2'b00, i_reg};
                    mlast_next = (i_reg == 2'd3);
                    msat_next  = flag_reg;
                    if (i_reg == 2'd3) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            ST_RD_RED: begin
                if (a_reg >= A_FULL) begin
                    a_next = a_reg - A_FULL;
                end else if (a_reg <= -A_FULL) begin
                    a_next = a_reg + A_FULL;
                end else begin
                    state_next = ST_RD_FOLD;
                end
            end
            ST_RD_FOLD: begin
                if (a_reg >= A_HALF) begin
                    a_next = a_reg - A_FULL;
                end else if (a_reg < -A_HALF) begin
                    a_next = a_reg + A_FULL;
                end
                state_next = ST_RD_QUAD;
            end
            ST_RD_QUAD: begin
                flip_next = 1'b0;
                if (a_reg > A_QUARTER) begin
                    a_next    = a_reg - A_HALF;
                    flip_next = 1'b1;
                end else if (a_reg < -A_QUARTER) begin
                    a_next    = a_reg + A_HALF;
                    flip_next = 1'b1;
                end
                state_next = ST_RD_MUL;
            end
            ST_RD_MUL: begin
                mul_a      = CW'(a_reg);
                mul_b      = RAD_PER_DEG;
                state_next = ST_RD_ZINIT;
            end
            ST_RD_ZINIT: begin
                c_start    = 1'b1;
                z_start    = CW'(rnd(prod_reg, FRAC_BITS + 2));
                state_next = ST_RD_CORDIC;
            end
            ST_RD_CORDIC: begin
                if (c_done) begin
                    state_next = ST_RD_TRIG;
                end
            end
            ST_RD_TRIG: begin
                c_next     = flip_reg ? -cx : cx;
                s_next     = flip_reg ? -cy : cy;
                t_next     = CW'(longint'(1) << 30) - (flip_reg ? -cx : cx);
                i_next     = '0;
                j_next     = '0;
                state_next = ST_RT_PMUL;
            end
            ST_RT_PMUL: begin
                mul_a      = CW'(v_reg[i_reg]);
                mul_b      = CW'(v_reg[j_reg]);
                state_next = ST_RT_PSAT;
            end
            ST_RT_PSAT: begin
                p_next     = sat32(r_fb);
                flag_next  = flag_reg | ovf32(r_fb);
                state_next = ST_RT_TMUL;
            end
            ST_RT_TMUL: begin
                mul_a      = CW'(p_reg);
                mul_b      = t_reg;
                state_next = ST_RT_DIAG;
            end
            ST_RT_DIAG, ST_RT_CROSS: begin
                if (state_reg == ST_RT_CROSS) begin
                    if ((i_reg == 2'd1 && j_reg == 2'd0) || (i_reg == 2'd2 && j_reg == 2'd1)
                        || (i_reg == 2'd0 && j_reg == 2'd2)) begin
                        ev = acc_reg + r_30;
                    end else begin
                        ev = acc_reg - r_30;
                    end
                end else begin
                    ev = r_30 + rnd(PW'(c_reg), 30 - FRAC_BITS);
                end
                if (state_reg == ST_RT_DIAG && i_reg != j_reg) begin
                    acc_next   = r_30;
                    state_next = ST_RT_CMUL;
                end else begin
                    rot_next[4'({2'b00, i_reg} * 4'd3) + {2'b00, j_reg}] = sat32(ev);
                    flag_next  = flag_reg | ovf32(ev);
                    state_next = ST_RT_PMUL;
                    if (j_reg == 2'd2) begin
                        j_next = '0;
                        if (i_reg == 2'd2) begin
                            i_next     = '0;
                            k_next     = '0;
                            acc_next   = '0;
                            state_next = ST_MM_MUL;
                        end else begin
                            i_next = i_reg + 1'b1;
                        end
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            ST_RT_CMUL: begin
                mul_a      = CW'(v_reg[kk]);
                mul_b      = s_reg;
                state_next = ST_RT_CROSS;
            end
            ST_MM_MUL: begin
                mul_a      = CW'(rot_reg[rot_idx]);
                mul_b      = CW'(mat_reg[{k_reg, j_reg}]);
                state_next = ST_MM_ACC;
            end
            ST_MM_ACC: begin
                state_next = ST_MM_MUL;
                if (k_reg == 2'd2) begin
                    col_next[i_reg] = sat32(accsum);
                    flag_next       = flag_reg | ovf32(accsum);
                    acc_next        = '0;
                    k_next          = '0;
                    if (i_reg == 2'd2) begin
                        state_next = ST_MM_WB;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    acc_next = accsum;
                    k_next   = k_reg + 1'b1;
                end
            end
            ST_MM_WB: begin
                mat_next[{2'd0, j_reg}] = col_reg[0];
                mat_next[{2'd1, j_reg}] = col_reg[1];
                mat_next[{2'd2, j_reg}] = col_reg[2];
                i_next = '0;
                if (j_reg == 2'd2) begin
                    state_next = ST_RT_FIN;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_MM_MUL;
                end
            end
            ST_RT_FIN: begin
                mat_next[12] = '0;
                mat_next[13] = '0;
                mat_next[14] = '0;
                mat_next[15] = ONE;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mval_next  = e_val_reg;
                    mpos_next  = e_pos_reg;
                    mlast_next = 1'b1;
                    msat_next  = flag_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        prod_next = PW'(mul_a) * PW'(mul_b);
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = mv_reg;
    assign m_value     = mval_reg;
    assign m_position  = mpos_reg;
    assign m_last      = mlast_reg;
    assign m_saturated = msat_reg;

endmodule
